>>> hw/rtl/mh2_pkg.sv
// mh2_pkg: shared types, constants and helpers for the murmur2 32-bit hash core
// no dependencies

package mh2_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam logic [31:0] SEED_RESET = 32'hc70f6907;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam int unsigned AVAL_SHIFT_A = 13;
  localparam int unsigned AVAL_SHIFT_B = 15;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_WORD   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORD_K,
    S_WORD_H,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    MS_DATA,
    MS_K,
    MS_H,
    MS_TAIL,
    MS_AVAL
  } mul_sel_t;

  typedef struct packed {
    logic     begin_load;
    logic     k_load;
    logic     h_mix;
    logic     h_tail;
    logic     out_load;
    mul_sel_t mul_sel;
  } cmd_t;

  function automatic logic [31:0] tail_bits(input logic [31:0] data, input logic [1:0] cnt);
    logic [31:0] res;
    res = '0;
    case (cnt)
      2'd0: res = '0;
      2'd1: res = data & 32'h0000_00ff;
      2'd2: res = data & 32'h0000_ffff;
      2'd3: res = data & 32'h00ff_ffff;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/mh2_if.sv
// mh2_if: valid/ready channel interfaces for input, result and seed write
// no dependencies

interface mh2_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] length;
  logic [31:0] data_word;
  logic [1:0]  tail_count;

  modport source (output valid, op, length, data_word, tail_count, input ready);
  modport sink (input valid, op, length, data_word, tail_count, output ready);
endinterface

interface mh2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, hash, input ready);
  modport sink (input valid, hash, output ready);
endinterface

interface mh2_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/mh2_ctrl.sv
// mh2_ctrl: sequencing state machine, message-open flag and result valid
// depends on mh2_pkg

module mh2_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output mh2_pkg::cmd_t cmd
);
  import mh2_pkg::*;

  state_t state_r, state_nxt;
  logic   open_r, open_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    open_nxt  = open_r;
    cmd       = '{begin_load: 1'b0, k_load: 1'b0, h_mix: 1'b0, h_tail: 1'b0,
                  out_load: 1'b0, mul_sel: MS_DATA};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_BEGIN) begin
            cmd.begin_load = 1'b1;
            open_nxt       = 1'b1;
          end else if (in_op == OP_WORD && open_r) begin
            cmd.k_load  = 1'b1;
            cmd.mul_sel = MS_DATA;
            state_nxt   = S_WORD_K;
          end else if (in_op == OP_FINISH && open_r) begin
            cmd.h_tail  = 1'b1;
            cmd.mul_sel = MS_TAIL;
            open_nxt    = 1'b0;
            state_nxt   = S_FIN;
          end
        end
      end
      S_WORD_K: begin
        cmd.k_load  = 1'b1;
        cmd.mul_sel = MS_K;
        state_nxt   = S_WORD_H;
      end
      S_WORD_H: begin
        cmd.h_mix   = 1'b1;
        cmd.mul_sel = MS_H;
        state_nxt   = S_IDLE;
      end
      S_FIN: begin
        cmd.mul_sel = MS_AVAL;
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

>>> hw/rtl/mh2_dp.sv
// mh2_dp: seed, running hash and mix registers around one shared constant multiplier
// depends on mh2_pkg

module mh2_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  mh2_pkg::cmd_t cmd,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data,
  input  logic [31:0]   in_length,
  input  logic [31:0]   in_data_word,
  input  logic [1:0]    in_tail_count,
  output logic [31:0]   out_hash
);
  import mh2_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      MS_DATA: mul_a = in_data_word;
      MS_K:    mul_a = k_r ^ (k_r >> MIX_SHIFT);
      MS_H:    mul_a = h_r;
      MS_TAIL: mul_a = h_r ^ tail_bits(in_data_word, in_tail_count);
      MS_AVAL: mul_a = h_r ^ (h_r >> AVAL_SHIFT_A);
      default: mul_a = h_r;
    endcase
  end

  assign prod = mul_a * MIX_MUL;

  always_comb begin
    seed_nxt = cfg_we ? cfg_data : seed_r;
    k_nxt    = cmd.k_load ? prod : k_r;
    hash_nxt = cmd.out_load ? (prod ^ (prod >> AVAL_SHIFT_B)) : hash_r;
    h_nxt    = h_r;
    if (cmd.begin_load) begin
      h_nxt = seed_r ^ in_length;
    end else if (cmd.h_mix) begin
      h_nxt = prod ^ k_r;
    end else if (cmd.h_tail && in_tail_count != 2'd0) begin
      h_nxt = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
      h_r    <= '0;
    end else begin
      seed_r <= seed_nxt;
      h_r    <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    hash_r <= hash_nxt;
  end

  assign out_hash = hash_r;

endmodule

>>> hw/rtl/murmur2_32_hash_core.sv
// murmur2_32_hash_core: 32-bit murmur2 hash, one message per begin/word/finish sequence
// depends on mh2_pkg, mh2_if, mh2_ctrl, mh2_dp
// begin loads the running hash on acceptance; a full word chains three products on one multiplier
// finish mixes in the tail, then S_FIN loads the hash once the output register is free
// one transaction in flight at a time; a finished hash waits in the output register
// synchronous active-low reset: seed back to its default, no message open, no result

module murmur2_32_hash_core (
  input  logic       clk,
  input  logic       rst_n,
  mh2_in_if.sink     in_ch,
  mh2_out_if.source  out_ch,
  mh2_cfg_if.sink    cfg_ch
);
  import mh2_pkg::*;

  cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  mh2_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  mh2_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_ch.valid),
    .cfg_data      (cfg_ch.data),
    .in_length     (in_ch.length),
    .in_data_word  (in_ch.data_word),
    .in_tail_count (in_ch.tail_count),
    .out_hash      (out_ch.hash)
  );

endmodule

>>> hw/rtl/mh2_chk.sv
// mh2_chk: port-level assertions for the hash core, bound to the top level
// depends on mh2_pkg and murmur2_32_hash_core

module mh2_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash
);
  import mh2_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hash_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hash))
    else $error("hash changed while stalled");

  a_rise_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_op == OP_FINISH, 2))
    else $error("result without a finish transaction");

  a_begin_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_BEGIN |=> in_ready)
    else $error("begin did not complete in one cycle");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind murmur2_32_hash_core mh2_chk u_mh2_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hash  (out_ch.hash)
);
